// File: src/assert_macros.svh
// Assertion macros used by the checker file tbb_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: src/tbb_pkg.sv
// Types and constants for the transformed bounding box block.
// No dependencies; imported by every module of the block.
package tbb_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int NUM_AXES  = 3;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	// sum of three full products, then floor shift and translation add
	localparam int PROD_W  = 2 * COORD_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int WHOLE_W = SUM_W - FRAC_BITS + 1;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam int IN_DATA_W  = NUM_AXES * COORD_W;
	localparam int OUT_DATA_W = 2 * NUM_AXES * COORD_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

	// fixed-point 1.0 in the low and high half of a register
	localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
	localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << COORD_W;

	typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec_t;

	typedef struct packed {
		logic last;
		vec_t p;
	} vtx_t;

	typedef struct packed {
		vec_t center;
		vec_t size;
	} res_t;

endpackage

// File: src/tbb_xform.sv
// Front end: matrix registers, vertex intake and the 4-stage affine transform.
// Depends on tbb_pkg; pushes transformed vertices into tbb_queue.
module tbb_xform import tbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vtx_t                 in_vtx,
	input  logic [QCNT_W-1:0]    q_count,
	output logic                 push_valid,
	output vtx_t                 push_vtx
);

	localparam int CREDIT_W = QCNT_W + 1;

	logic [CFG_W-1:0] row01_q [NUM_AXES];
	logic [CFG_W-1:0] row23_q [NUM_AXES];

	logic v_s1, v_s2, v_s3, v_s4;
	vtx_t pt_s1;
	logic last_s2, last_s3, last_s4;
	logic signed [PROD_W-1:0] prod_s2 [NUM_AXES][NUM_AXES];
	logic signed [SUM_W-1:0]  sum_s3 [NUM_AXES];
	vec_t t_s4;

	logic [COORD_W-1:0] coef [NUM_AXES][NUM_AXES];
	logic [COORD_W-1:0] trans [NUM_AXES];
	logic signed [WHOLE_W-1:0] whole [NUM_AXES];
	logic [CREDIT_W-1:0] credit_used;
	logic accept;

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [WHOLE_W-1:0] w);
		logic [WHOLE_W-COORD_W:0] upper;
		upper = w[WHOLE_W-1:COORD_W-1];
		if (&upper || ~|upper)
			return w[COORD_W-1:0];
		else if (w[WHOLE_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	always_comb begin
		for (int r = 0; r < NUM_AXES; r++) begin
			coef[r][0] = row01_q[r][COORD_W-1:0];
			coef[r][1] = row01_q[r][CFG_W-1:COORD_W];
			coef[r][2] = row23_q[r][COORD_W-1:0];
			trans[r]   = row23_q[r][CFG_W-1:COORD_W];
		end
	end

	// every in-flight vertex has a queue slot reserved for it
	assign credit_used = CREDIT_W'(q_count) + CREDIT_W'(v_s1) + CREDIT_W'(v_s2)
		+ CREDIT_W'(v_s3) + CREDIT_W'(v_s4);
	assign in_ready = credit_used < CREDIT_W'(QDEPTH);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row01_q[0] <= ONE_LO;
			row23_q[0] <= '0;
			row01_q[1] <= ONE_HI;
			row23_q[1] <= '0;
			row01_q[2] <= '0;
			row23_q[2] <= ONE_LO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW0_COLS01: row01_q[0] <= cfg_data;
				REG_ROW0_COLS23: row23_q[0] <= cfg_data;
				REG_ROW1_COLS01: row01_q[1] <= cfg_data;
				REG_ROW1_COLS23: row23_q[1] <= cfg_data;
				REG_ROW2_COLS01: row01_q[2] <= cfg_data;
				REG_ROW2_COLS23: row23_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int r = 0; r < NUM_AXES; r++) begin
			// floor of the product sum by the fraction bits, then translation
			whole[r] = WHOLE_W'($signed(sum_s3[r][SUM_W-1:FRAC_BITS]))
				+ WHOLE_W'($signed(trans[r]));
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pt_s1 <= in_vtx;
		last_s2 <= pt_s1.last;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
		for (int r = 0; r < NUM_AXES; r++) begin
			for (int c = 0; c < NUM_AXES; c++)
				prod_s2[r][c] <= $signed(coef[r][c]) * $signed(pt_s1.p[c]);
			sum_s3[r] <= SUM_W'(prod_s2[r][0]) + SUM_W'(prod_s2[r][1])
				+ SUM_W'(prod_s2[r][2]);
			t_s4[r] <= sat_coord(whole[r]);
		end
	end

	assign push_valid    = v_s4;
	assign push_vtx.last = last_s4;
	assign push_vtx.p    = t_s4;

endmodule

// File: src/tbb_queue.sv
// Small FIFO of transformed vertices between the transform and the box tracker.
// Depends on tbb_pkg. Push is never refused: the front end reserves slots.
module tbb_queue import tbb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  vtx_t              push_vtx,
	input  logic              pop,
	output logic              head_valid,
	output vtx_t              head_vtx,
	output logic [QCNT_W-1:0] count
);

	vtx_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({push_valid, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid)
			mem_q[wr_ptr_q] <= push_vtx;
	end

	assign head_valid = count_q != '0;
	assign head_vtx   = mem_q[rd_ptr_q];
	assign count      = count_q;

endmodule

// File: src/tbb_bounds.sv
// Back end: running per-axis min/max and the size/center result register.
// Depends on tbb_pkg; drains tbb_queue.
module tbb_bounds import tbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  vtx_t head_vtx,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic seeded_q;
	logic out_valid_q;
	vec_t lo_q, hi_q;
	res_t res_q;

	vec_t nlo, nhi;
	res_t res_next;
	logic signed [COORD_W:0] mid_sum [NUM_AXES];

	// a final vertex waits until the result register is free
	assign pop = head_valid && (!head_vtx.last || !out_valid_q || out_ready);

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			if (!seeded_q || $signed(head_vtx.p[i]) < $signed(lo_q[i]))
				nlo[i] = head_vtx.p[i];
			else
				nlo[i] = lo_q[i];
			if (!seeded_q || $signed(head_vtx.p[i]) > $signed(hi_q[i]))
				nhi[i] = head_vtx.p[i];
			else
				nhi[i] = hi_q[i];
			mid_sum[i] = (COORD_W+1)'($signed(nlo[i])) + (COORD_W+1)'($signed(nhi[i]));
			res_next.size[i]   = nhi[i] - nlo[i];
			res_next.center[i] = mid_sum[i][COORD_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				seeded_q <= !head_vtx.last;
			if (pop && head_vtx.last)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lo_q <= nlo;
			hi_q <= nhi;
			if (head_vtx.last)
				res_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

// File: src/transformed_bounding_box.sv
// A final vertex passes the 4 transform stages and the queue, then the result register.
// Throughput: one vertex per cycle; s_axis_tready drops only when the 4 transform
// stages plus the 8-entry queue hold 8 vertices, i.e. when the output side stalls.
// Reset (arst_n low, asynchronous) empties the pipeline, queue and result register,
// clears the box and loads the identity matrix; corner registers are not cleared.
module transformed_bounding_box import tbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // vertex_x, vertex_y, vertex_z
	input  logic                  s_axis_tlast,  // is_final
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // size_x/y/z, center_x/y/z
);

	vtx_t in_vtx, push_vtx, head_vtx;
	logic push_valid, pop, head_valid;
	logic [QCNT_W-1:0] q_count;
	res_t out_res;

	assign cfg_ready   = 1'b1;
	assign in_vtx.last = s_axis_tlast;
	assign in_vtx.p    = s_axis_tdata;

	tbb_xform u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_vtx     (in_vtx),
		.q_count    (q_count),
		.push_valid (push_valid),
		.push_vtx   (push_vtx)
	);

	tbb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_vtx   (push_vtx),
		.pop        (pop),
		.head_valid (head_valid),
		.head_vtx   (head_vtx),
		.count      (q_count)
	);

	tbb_bounds u_bounds (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_vtx   (head_vtx),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = out_res;

endmodule

// File: src/tbb_checker.sv
// Port-level checks for transformed_bounding_box, bound to the top level.
// Depends on tbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbb_checker import tbb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int PEND_W = QCNT_W + 1;

	logic [PEND_W-1:0] pending_q;
	logic fin_acc, out_acc;

	assign fin_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// final vertices accepted whose box has not been delivered yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			unique case ({fin_acc, out_acc})
				2'b10:   pending_q <= pending_q + PEND_W'(1);
				2'b01:   pending_q <= pending_q - PEND_W'(1);
				default: pending_q <= pending_q;
			endcase
		end
	end

	`ASSERT_NXT(a_out_valid_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_NXT(a_out_data_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`ASSERT_IMP(a_out_has_source, clk, arst_n, m_axis_tvalid, pending_q != '0)
	`ASSERT_IMP(a_pending_bound, clk, arst_n, 1'b1, pending_q <= PEND_W'(QDEPTH + 1))

endmodule

bind transformed_bounding_box tbb_checker u_tbb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: dv/transformed_bounding_box_tb.sv
// Self-checking bench for transformed_bounding_box: vertex runs under several matrix
// settings, each box checked against a local fixed-point model or a given expected box.
// Depends on tbb_pkg and the transformed_bounding_box RTL only.
`timescale 1ns / 100ps

module transformed_bounding_box_tb;
	import tbb_pkg::*;

	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{REG_ROW0_COLS01, REG_ROW0_COLS23,
		REG_ROW1_COLS01, REG_ROW1_COLS23, REG_ROW2_COLS01, REG_ROW2_COLS23};

	typedef enum int {MAT_IDENT, MAT_FRACT, MAT_WILD, MAT_LIMITS} mat_mode_t;

	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		vtx_t                 v;
		bit                   typed;
		res_t                 want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // vertex_x, vertex_y, vertex_z
	logic                  s_axis_tlast = 1'b0; // is_final
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // size_x/y/z, center_x/y/z

	// local copy of the matrix and of the running box
	logic [CFG_W-1:0]          matrix [6];
	logic signed [COORD_W-1:0] box_lo [NUM_AXES];
	logic signed [COORD_W-1:0] box_hi [NUM_AXES];
	bit                        box_open = 1'b0;

	res_t        box_due [$];
	int unsigned fail_count = 0;
	int unsigned burst_left = 0;
	bit          pressure_go = 1'b0;
	string       AXIS [NUM_AXES] = '{"x", "y", "z"};

	transformed_bounding_box dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("transformed_bounding_box_tb: errors");
				$finish;
			end
		end
	end

	function automatic vec_t mk_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		vec_t r;
		r[0] = x;
		r[1] = y;
		r[2] = z;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] ident_reg(logic [CFG_IDX_W-1:0] idx);
		case (idx)
			REG_ROW0_COLS01: return ONE_LO;
			REG_ROW1_COLS01: return ONE_HI;
			REG_ROW2_COLS23: return ONE_LO;
			default:         return '0;
		endcase
	endfunction

	// floor of the exact dot product plus translation, then clamp to 32 bits
	function automatic logic signed [COORD_W-1:0] transform_axis(logic [CFG_W-1:0] c01,
			logic [CFG_W-1:0] c23, vec_t p);
		logic signed [SUM_W+1:0] acc;
		logic signed [SUM_W+1:0] whole;
		acc = $signed(c01[31:0]) * $signed(p[0]) + $signed(c01[63:32]) * $signed(p[1])
			+ $signed(c23[31:0]) * $signed(p[2]);
		whole = (acc >>> FRAC_BITS) + $signed(c23[63:32]);
		if (whole > S32_MAX)
			return S32_MAX;
		if (whole < S32_MIN)
			return S32_MIN;
		return whole[COORD_W-1:0];
	endfunction

	task automatic predict_box(input vtx_t v, output bit has_box, output res_t r);
		logic signed [COORD_W-1:0] t;
		logic signed [COORD_W:0]   mid;
		for (int a = 0; a < NUM_AXES; a++) begin
			t = transform_axis(matrix[2 * a], matrix[2 * a + 1], v.p);
			if (!box_open) begin
				box_lo[a] = t;
				box_hi[a] = t;
			end else begin
				if (t < box_lo[a]) box_lo[a] = t;
				if (t > box_hi[a]) box_hi[a] = t;
			end
		end
		box_open = 1'b1;
		has_box = v.last;
		r = '0;
		if (v.last) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				mid = box_lo[a] + box_hi[a];
				r.size[a] = box_hi[a] - box_lo[a];
				r.center[a] = mid[COORD_W:1];
			end
			box_open = 1'b0;
		end
	endtask

	task automatic send_vertex(input vtx_t v, input bit typed, input res_t want);
		bit   has_box;
		res_t r;
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v.p;
		s_axis_tlast <= v.last;
		do @(posedge clk); while (!s_axis_tready);
		predict_box(v, has_box, r);
		if (has_box)
			box_due = {box_due, (typed ? want : r)};
		burst_left--;
		if (burst_left == 0)
			s_axis_tvalid <= 1'b0;
	endtask

	// only written with the stream quiet and every box request delivered
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		if (burst_left != 0) begin
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
		end
		while (box_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		matrix[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_half(mat_mode_t mode);
		case (mode)
			MAT_FRACT: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
			MAT_LIMITS: begin
				case ($urandom_range(0, 4))
					0:       return 32'h7fff_ffff;
					1:       return 32'h8000_0000;
					2:       return 32'h0000_0000;
					3:       return 32'hffff_ffff;
					default: return 32'h0001_0000;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_reg(mat_mode_t mode, logic [CFG_IDX_W-1:0] idx);
		logic [CFG_W-1:0] val;
		if (mode == MAT_IDENT) begin
			val = ident_reg(idx);
			// translation halves get a small random offset
			if (idx == REG_ROW0_COLS23 || idx == REG_ROW1_COLS23 || idx == REG_ROW2_COLS23)
				val[63:32] = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
			return val;
		end
		return {rand_half(mode), rand_half(mode)};
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			8:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			9:          return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
			default:    return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		endcase
	endfunction

	function automatic plan_row_t vtx_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit last);
		plan_row_t row;
		row = '{default: '0};
		row.v.p = mk_vec(x, y, z);
		row.v.last = last;
		return row;
	endfunction

	function automatic plan_row_t chk_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			vec_t size, vec_t center);
		plan_row_t row;
		row = vtx_row(x, y, z, 1'b1);
		row.typed = 1'b1;
		row.want.size = size;
		row.want.center = center;
		return row;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		plan_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.idx = idx;
		row.data = val;
		return row;
	endfunction

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endfunction

	initial begin : drain
		int unsigned hold_left;
		int unsigned tick;
		bit          pressure_done;
		res_t        got;
		res_t        want;
		hold_left = 0;
		tick = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata);
				if (box_due.size() == 0) begin
					$error("box result with no request pending: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = box_due.pop_front();
					for (int a = 0; a < NUM_AXES; a++) begin
						cmp_field({"size_", AXIS[a]}, want.size[a], got.size[a]);
						cmp_field({"center_", AXIS[a]}, want.center[a], got.center[a]);
					end
				end
			end
			tick++;
			if (pressure_go && !pressure_done) begin
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case ((tick / 97) % 3)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
					default: m_axis_tready <= ((tick % 5) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		plan_row_t   plan [$];
		vtx_t        v;
		int unsigned n;
		int unsigned run_len;
		foreach (REG_ORDER[i]) matrix[REG_ORDER[i]] = ident_reg(REG_ORDER[i]);
		plan = '{
			// lone final vertex right after reset: zero size, center on the vertex
			chk_row(32'h0001_0000, 32'hfffe_0000, 32'h0003_0000, '0,
				mk_vec(32'h0001_0000, 32'hfffe_0000, 32'h0003_0000)),
			// full signed range on every axis
			vtx_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0),
			chk_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1, '1),
			vtx_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0),
			vtx_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0),
			vtx_row(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 1'b0),
			vtx_row(32'haaaa_aaaa, 32'h5555_5555, 32'h8765_4321, 1'b1),
			// huge coefficients so the transform clamps both ways
			reg_row(REG_ROW0_COLS01, 64'h7fff_ffff_7fff_ffff),
			reg_row(REG_ROW1_COLS01, 64'h8000_0000_8000_0000),
			reg_row(REG_ROW2_COLS23, 64'h7fff_ffff_8000_0000),
			vtx_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 1'b0),
			vtx_row(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 1'b0),
			vtx_row(32'h0001_0000, 32'hffff_0000, 32'h0000_0000, 1'b1),
			// all-zero matrix collapses every vertex to the origin
			reg_row(REG_ROW0_COLS01, '0),
			reg_row(REG_ROW0_COLS23, '0),
			reg_row(REG_ROW1_COLS01, '0),
			reg_row(REG_ROW1_COLS23, '0),
			reg_row(REG_ROW2_COLS01, '0),
			reg_row(REG_ROW2_COLS23, '0),
			vtx_row(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0005, 1'b0),
			chk_row(32'h8000_0000, 32'h7fff_ffff, 32'hffff_fffb, '0, '0),
			// all-ones matrix: every coefficient and offset is the smallest negative step
			reg_row(REG_ROW0_COLS01, '1),
			reg_row(REG_ROW0_COLS23, '1),
			reg_row(REG_ROW1_COLS01, '1),
			reg_row(REG_ROW1_COLS23, '1),
			reg_row(REG_ROW2_COLS01, '1),
			reg_row(REG_ROW2_COLS23, '1),
			vtx_row(32'h7fff_ffff, 32'h0001_8000, 32'h8000_0000, 1'b0),
			vtx_row(32'h0000_0001, 32'hffff_ffff, 32'h0000_ffff, 1'b1)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_vertex(plan[i].v, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < 8; ph++) begin
			mat_mode_t mode;
			mode = mat_mode_t'(ph % 4);
			foreach (REG_ORDER[i]) write_reg(REG_ORDER[i], rand_reg(mode, REG_ORDER[i]));
			// first random phase runs into the long output hold-off
			if (ph == 0)
				pressure_go = 1'b1;
			n = 0;
			while (n < 50) begin
				run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (int k = 0; k < run_len; k++) begin
					v.p = mk_vec(rand_coord(), rand_coord(), rand_coord());
					v.last = (k == run_len - 1);
					send_vertex(v, 1'b0, '0);
					n++;
				end
			end
		end

		if (burst_left != 0)
			s_axis_tvalid <= 1'b0;
		while (box_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("transformed_bounding_box_tb: clean");
		else
			$display("transformed_bounding_box_tb: errors");
		$finish;
	end

endmodule
